FILE: rtl/maze_dfs_walker_defines.svh
// Assertion macros used by the checker file.
`ifndef MAZE_DFS_WALKER_DEFINES_SVH
`define MAZE_DFS_WALKER_DEFINES_SVH

// Same-cycle implication, ignored while reset is low.
`define MDW_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is low.
`define MDW_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mdw_pkg.sv
`default_nettype none

package mdw_pkg;

  // Fixed field widths
  localparam int COORD_W = 5;
  localparam int CFG_DW  = 6;
  localparam int CFG_IW  = 2;

  // Default grid storage size
  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 32;

  // Command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_BEGIN = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  // Cell codes
  localparam logic [1:0] CELL_OPEN    = 2'd0;
  localparam logic [1:0] CELL_WALL    = 2'd1;
  localparam logic [1:0] CELL_VISITED = 2'd2;
  localparam logic [1:0] CELL_DEAD    = 2'd3;

  // Neighbor scan order
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] REG_ROWS      = 2'd0;
  localparam logic [CFG_IW-1:0] REG_COLS      = 2'd1;
  localparam logic [CFG_IW-1:0] REG_START_ROW = 2'd2;
  localparam logic [CFG_IW-1:0] REG_START_COL = 2'd3;

  // Configuration reset values
  localparam logic [CFG_DW-1:0]  RST_ROWS      = 6'd32;
  localparam logic [CFG_DW-1:0]  RST_COLS      = 6'd32;
  localparam logic [COORD_W-1:0] RST_START_ROW = 5'd1;
  localparam logic [COORD_W-1:0] RST_START_COL = 5'd0;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_LOADTOP,
    S_RESP
  } mdw_state_t;

endpackage

`default_nettype wire

FILE: rtl/maze_dfs_walker.sv
`default_nettype none
// Channel   | Ports                                      | Handshake
// ----------+--------------------------------------------+------------------------------
// input     | in_cmd, in_row, in_col, in_cell_value      | start & !busy
// result    | out_cur_row/col, advanced, done_res, stuck | out_valid, one cycle
// config    | cfg_index, cfg_data                        | cfg_valid & cfg_ready
//
// Write, begin and unknown commands, and a step on an empty stack or a finished walk: result
// strobe in the cycle after accept, busy only while it is shown. Step: scan of four neighbors
// through the single grid read port (S_SCAN), update (S_DECIDE), a stack read (S_LOADTOP) on a
// backtrack that leaves the stack non-empty, then the result, with busy high until it ends.
// After reset the grid is swept to wall, one cell a cycle; busy stays high meanwhile. Config is
// always ready. The result cannot be stalled; it is shown exactly while out_valid is high.

module maze_dfs_walker #(
  parameter int MAX_ROWS = mdw_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = mdw_pkg::DEF_MAX_COLS
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // input item
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_cmd,
  input  wire logic [mdw_pkg::COORD_W-1:0]  in_row,
  input  wire logic [mdw_pkg::COORD_W-1:0]  in_col,
  input  wire logic [1:0]                   in_cell_value,
  // result item
  output logic                              out_valid,
  output logic [mdw_pkg::COORD_W-1:0]       out_cur_row,
  output logic [mdw_pkg::COORD_W-1:0]       out_cur_col,
  output logic                              out_advanced,
  output logic                              out_done_res,
  output logic                              out_stuck,
  // configuration
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [mdw_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [mdw_pkg::CFG_DW-1:0]   cfg_data
);
  import mdw_pkg::*;

  // Storage geometry
  localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int PRW        = (ROW_W > COORD_W) ? ROW_W : COORD_W;
  localparam int PCW        = (COL_W > COORD_W) ? COL_W : COORD_W;
  localparam int GAW        = ROW_W + COL_W;
  localparam int GRID_DEPTH = MAX_ROWS * (2 ** COL_W);
  localparam int SDEPTH     = MAX_ROWS * MAX_COLS;
  localparam int SAW        = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int CNT_W      = $clog2(SDEPTH + 1);
  localparam int SEW        = PRW + PCW;
  localparam logic [2:0] K_LAST = 3'd4;

  mdw_state_t state_r, state_nxt;

  logic [GAW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [CFG_DW-1:0]  rows_r, rows_nxt, cols_r, cols_nxt;
  logic [COORD_W-1:0] srow_r, srow_nxt, scol_r, scol_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               fin_r, fin_nxt;
  logic               adv_r, adv_nxt;
  logic [PRW-1:0]     top_row_r, top_row_nxt;
  logic [PCW-1:0]     top_col_r, top_col_nxt;
  logic [2:0]         k_r, k_nxt;
  logic               pend_ok_r, pend_ok_nxt;
  logic [PRW-1:0]     pend_row_r, pend_row_nxt;
  logic [PCW-1:0]     pend_col_r, pend_col_nxt;
  logic               found_r, found_nxt;
  logic [PRW-1:0]     nbr_row_r, nbr_row_nxt;
  logic [PCW-1:0]     nbr_col_r, nbr_col_nxt;
  logic [2:0]         vis_r, vis_nxt;

  // Memories and their ports
  logic [1:0]     grid_mem [GRID_DEPTH];
  logic [SEW-1:0] stk_mem  [SDEPTH];
  logic           g_we;
  logic [GAW-1:0] g_waddr, g_raddr;
  logic [1:0]     g_wdata, g_rdata_r;
  logic           s_we;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [SEW-1:0] s_wdata, s_rdata_r;

  // Neighbor unit signals
  logic [PRW:0]   nb_row;
  logic [PCW:0]   nb_col;
  logic           nb_neg, nb_ok;
  logic [GAW-1:0] nb_addr;
  logic           top_in, at_exit, wr_in;
  logic [PRW-1:0] in_row_w;
  logic [PCW-1:0] in_col_w;
  logic [PRW:0]   top_row_p2;
  logic [PCW:0]   top_col_p1;
  logic [CNT_W-1:0] cnt_m2;
  logic [1:0]     scan_v;

  // Shared neighbor address unit: one offset, bounds check and address per cycle
  always_comb begin : p_nbr
    nb_row = {1'b0, top_row_r};
    nb_col = {1'b0, top_col_r};
    nb_neg = 1'b0;
    case (k_r[1:0])
      DIR_UP: begin
        nb_neg = (top_row_r == '0);
        nb_row = {1'b0, top_row_r} - (PRW+1)'(1);
      end
      DIR_LEFT: begin
        nb_neg = (top_col_r == '0);
        nb_col = {1'b0, top_col_r} - (PCW+1)'(1);
      end
      DIR_RIGHT: nb_col = {1'b0, top_col_r} + (PCW+1)'(1);
      DIR_DOWN:  nb_row = {1'b0, top_row_r} + (PRW+1)'(1);
      default: ;
    endcase
    nb_ok = !nb_neg
         && (nb_row < (PRW+1)'(rows_r)) && (nb_row < (PRW+1)'(MAX_ROWS))
         && (nb_col < (PCW+1)'(cols_r)) && (nb_col < (PCW+1)'(MAX_COLS));
    nb_addr = {nb_row[ROW_W-1:0], nb_col[COL_W-1:0]};
  end

  // Storage bounds, exit match and helpers
  always_comb begin : p_misc
    in_row_w   = PRW'(in_row);
    in_col_w   = PCW'(in_col);
    wr_in      = ({1'b0, in_row_w} < (PRW+1)'(MAX_ROWS))
              && ({1'b0, in_col_w} < (PCW+1)'(MAX_COLS));
    top_in     = ({1'b0, top_row_r} < (PRW+1)'(MAX_ROWS))
              && ({1'b0, top_col_r} < (PCW+1)'(MAX_COLS));
    top_row_p2 = {1'b0, top_row_r} + (PRW+1)'(2);
    top_col_p1 = {1'b0, top_col_r} + (PCW+1)'(1);
    at_exit    = (top_row_p2 == (PRW+1)'(rows_r)) && (top_col_p1 == (PCW+1)'(cols_r));
    cnt_m2     = count_r - CNT_W'(2);
    scan_v     = pend_ok_r ? g_rdata_r : CELL_WALL;
  end

  // Next state
  always_comb begin : p_next
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:   if (clr_addr_r == GAW'(GRID_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (in_cmd == CMD_STEP && count_r != '0 && !fin_r) state_nxt = S_SCAN;
          else                                                state_nxt = S_RESP;
        end
      end
      S_SCAN:    if (k_r == K_LAST) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (!found_r && count_r != CNT_W'(1)) state_nxt = S_LOADTOP;
        else                                  state_nxt = S_RESP;
      end
      S_LOADTOP: state_nxt = S_RESP;
      S_RESP:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Port outputs
  always_comb begin : p_out
    busy         = (state_r != S_IDLE);
    cfg_ready    = 1'b1;
    out_valid    = (state_r == S_RESP);
    out_cur_row  = (count_r != '0) ? top_row_r[COORD_W-1:0] : '0;
    out_cur_col  = (count_r != '0) ? top_col_r[COORD_W-1:0] : '0;
    out_advanced = adv_r;
    out_done_res = fin_r;
    out_stuck    = (count_r == '0);
  end

  // Datapath and memory control
  always_comb begin : p_dp
    clr_addr_nxt = clr_addr_r;
    rows_nxt     = rows_r;
    cols_nxt     = cols_r;
    srow_nxt     = srow_r;
    scol_nxt     = scol_r;
    count_nxt    = count_r;
    fin_nxt      = fin_r;
    adv_nxt      = adv_r;
    top_row_nxt  = top_row_r;
    top_col_nxt  = top_col_r;
    k_nxt        = k_r;
    pend_ok_nxt  = pend_ok_r;
    pend_row_nxt = pend_row_r;
    pend_col_nxt = pend_col_r;
    found_nxt    = found_r;
    nbr_row_nxt  = nbr_row_r;
    nbr_col_nxt  = nbr_col_r;
    vis_nxt      = vis_r;
    g_we         = 1'b0;
    g_waddr      = {top_row_r[ROW_W-1:0], top_col_r[COL_W-1:0]};
    g_wdata      = CELL_VISITED;
    g_raddr      = nb_addr;
    s_we         = 1'b0;
    s_waddr      = count_r[SAW-1:0];
    s_wdata      = {nbr_row_r, nbr_col_r};
    s_raddr      = cnt_m2[SAW-1:0];

    // config writes
    if (cfg_valid) begin
      case (cfg_index)
        REG_ROWS:      rows_nxt = cfg_data;
        REG_COLS:      cols_nxt = cfg_data;
        REG_START_ROW: srow_nxt = cfg_data[COORD_W-1:0];
        REG_START_COL: scol_nxt = cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      // sweep the grid to wall
      S_CLEAR: begin
        g_we         = 1'b1;
        g_waddr      = clr_addr_r;
        g_wdata      = CELL_WALL;
        clr_addr_nxt = clr_addr_r + GAW'(1);
      end
      // command accept
      S_IDLE: begin
        if (start) begin
          adv_nxt     = 1'b0;
          k_nxt       = '0;
          found_nxt   = 1'b0;
          vis_nxt     = '0;
          pend_ok_nxt = 1'b0;
          case (in_cmd)
            CMD_WRITE: begin
              g_we    = wr_in;
              g_waddr = {in_row_w[ROW_W-1:0], in_col_w[COL_W-1:0]};
              g_wdata = in_cell_value;
            end
            CMD_BEGIN: begin
              count_nxt   = CNT_W'(1);
              fin_nxt     = 1'b0;
              top_row_nxt = PRW'(srow_r);
              top_col_nxt = PCW'(scol_r);
              s_we        = 1'b1;
              s_waddr     = '0;
              s_wdata     = {PRW'(srow_r), PCW'(scol_r)};
            end
            default: ;
          endcase
        end
      end
      // issue neighbor k, classify neighbor k-1
      S_SCAN: begin
        if (k_r != '0) begin
          if (scan_v == CELL_OPEN) begin
            if (!found_r) begin
              found_nxt   = 1'b1;
              nbr_row_nxt = pend_row_r;
              nbr_col_nxt = pend_col_r;
            end
          end else if (scan_v == CELL_VISITED) begin
            vis_nxt = vis_r + 3'd1;
          end
        end
        if (k_r != K_LAST) begin
          pend_ok_nxt  = nb_ok;
          pend_row_nxt = nb_row[PRW-1:0];
          pend_col_nxt = nb_col[PCW-1:0];
        end
        k_nxt = k_r + 3'd1;
      end
      // mark current cell, push or pop
      S_DECIDE: begin
        g_we = top_in;
        if (found_r) begin
          g_wdata = CELL_VISITED;
          if (count_r != CNT_W'(SDEPTH)) begin
            s_we        = 1'b1;
            count_nxt   = count_r + CNT_W'(1);
            top_row_nxt = nbr_row_r;
            top_col_nxt = nbr_col_r;
            adv_nxt     = 1'b1;
          end
          if (at_exit) fin_nxt = 1'b1;
        end else begin
          g_wdata   = (vis_r == 3'd1) ? CELL_DEAD : CELL_VISITED;
          count_nxt = count_r - CNT_W'(1);
          if (count_r != CNT_W'(1) && at_exit) fin_nxt = 1'b1;
        end
      end
      // new top after a pop
      S_LOADTOP: begin
        top_row_nxt = s_rdata_r[SEW-1:PCW];
        top_col_nxt = s_rdata_r[PCW-1:0];
      end
      default: ;
    endcase
  end

  // Control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      rows_r     <= RST_ROWS;
      cols_r     <= RST_COLS;
      srow_r     <= RST_START_ROW;
      scol_r     <= RST_START_COL;
      count_r    <= '0;
      fin_r      <= 1'b0;
      adv_r      <= 1'b0;
      k_r        <= '0;
      found_r    <= 1'b0;
      pend_ok_r  <= 1'b0;
      vis_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      rows_r     <= rows_nxt;
      cols_r     <= cols_nxt;
      srow_r     <= srow_nxt;
      scol_r     <= scol_nxt;
      count_r    <= count_nxt;
      fin_r      <= fin_nxt;
      adv_r      <= adv_nxt;
      k_r        <= k_nxt;
      found_r    <= found_nxt;
      pend_ok_r  <= pend_ok_nxt;
      vis_r      <= vis_nxt;
    end
    top_row_r  <= top_row_nxt;
    top_col_r  <= top_col_nxt;
    pend_row_r <= pend_row_nxt;
    pend_col_r <= pend_col_nxt;
    nbr_row_r  <= nbr_row_nxt;
    nbr_col_r  <= nbr_col_nxt;
  end

  // Grid memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (g_we) grid_mem[g_waddr] <= g_wdata;
    g_rdata_r <= grid_mem[g_raddr];
  end

  // Position stack memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (s_we) stk_mem[s_waddr] <= s_wdata;
    s_rdata_r <= stk_mem[s_raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/mdw_checker.sv
`default_nettype none
`include "maze_dfs_walker_defines.svh"

module mdw_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic [1:0]                   in_cmd,
  input wire logic [mdw_pkg::COORD_W-1:0]  in_row,
  input wire logic [mdw_pkg::COORD_W-1:0]  in_col,
  input wire logic [1:0]                   in_cell_value,
  input wire logic                         out_valid,
  input wire logic [mdw_pkg::COORD_W-1:0]  out_cur_row,
  input wire logic [mdw_pkg::COORD_W-1:0]  out_cur_col,
  input wire logic                         out_advanced,
  input wire logic                         out_done_res,
  input wire logic                         out_stuck,
  input wire logic                         cfg_valid,
  input wire logic                         cfg_ready,
  input wire logic [mdw_pkg::CFG_IW-1:0]   cfg_index,
  input wire logic [mdw_pkg::CFG_DW-1:0]   cfg_data
);

  // an accepted item raises busy in the next cycle
  `MDW_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

  // one result per item: the strobe is never held high
  `MDW_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe held for two cycles")

  // an empty stack reports position zero and no advance
  `MDW_IMPLIES(a_stuck_pos, out_valid && out_stuck,
    out_cur_row == 5'd0 && out_cur_col == 5'd0 && !out_advanced,
    "stuck result with position or advance set")

  // a finished walk always keeps a non-empty stack
  `MDW_IMPLIES(a_done_nonempty, out_valid && out_done_res, !out_stuck,
    "done reported together with stuck")

endmodule

bind maze_dfs_walker mdw_checker u_mdw_checker (.*);

`default_nettype wire
